// File: rtl/core/scbp_pkg.sv
// Shared types and constants of the size-class buffer pool.
package scbp_pkg;

    localparam int NumClasses   = 3;
    localparam int MaxInitial   = 64;
    localparam int StackDepth   = 128;
    localparam int IdWidth      = 7;
    localparam int AddrWidth    = 7;
    localparam int DepthWidth   = 8;
    localparam int CountWidth   = 7;
    localparam int SizeWidth    = 25;
    localparam int ReqWidth     = 32;
    localparam int StatWidth    = 32;

    typedef enum logic [1:0] {
        OP_ACQUIRE = 2'd0,
        OP_RELEASE = 2'd1,
        OP_INIT    = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_GRANT        = 3'd0,
        ST_FALLBACK     = 3'd1,
        ST_RELEASED     = 3'd2,
        ST_DROP_FULL    = 3'd3,
        ST_DROP_UNKNOWN = 3'd4,
        ST_INIT_DONE    = 3'd5
    } status_t;

    localparam logic [1:0] CLASS_SMALL  = 2'd0;
    localparam logic [1:0] CLASS_MEDIUM = 2'd1;
    localparam logic [1:0] CLASS_LARGE  = 2'd2;
    localparam logic [1:0] CLASS_NONE   = 2'd3;

    localparam logic [2:0] REG_SMALL_COUNT  = 3'd0;
    localparam logic [2:0] REG_MEDIUM_COUNT = 3'd1;
    localparam logic [2:0] REG_LARGE_COUNT  = 3'd2;
    localparam logic [2:0] REG_SMALL_SIZE   = 3'd3;
    localparam logic [2:0] REG_MEDIUM_SIZE  = 3'd4;
    localparam logic [2:0] REG_LARGE_SIZE   = 3'd5;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_OUT  = 1'b1
    } back_state_t;

    typedef struct packed {
        logic [CountWidth-1:0] count;
        logic [SizeWidth-1:0]  size;
    } class_cfg_t;

    typedef struct packed {
        opcode_t               opcode;
        logic [NumClasses-1:0] fits;
        logic [1:0]            match;
        logic [ReqWidth-1:0]   req;
        logic [IdWidth-1:0]    rid;
    } work_t;

    typedef struct packed {
        status_t               status;
        logic [1:0]            size_class;
        logic [IdWidth-1:0]    grant_id;
        logic [ReqWidth-1:0]   granted_size;
        logic [DepthWidth-1:0] small_free;
        logic [DepthWidth-1:0] medium_free;
        logic [DepthWidth-1:0] large_free;
        logic [StatWidth-1:0]  acquire_total;
        logic [StatWidth-1:0]  hit_total;
        logic [StatWidth-1:0]  miss_total;
        logic [StatWidth-1:0]  fallback_total;
    } result_t;

endpackage

// File: rtl/core/size_class_buffer_pool.sv
// Top level of the size-class buffer pool: configuration registers and the front and back ends.
//
// Each transaction passes through a two-entry queue and then through the back end: its
// idle state decides and updates the class stacks and counters while the read of the
// stack memory is issued, and its output state is where the registered read data loads
// the result register; a stalled result holds the back end in its output state.
// Initialisation is one transaction and needs no sweep of the memories, because entries
// below a per-class low-water mark are known to still hold their initial ids.
module size_class_buffer_pool (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [31:0] s_size_bytes,
    input  logic [6:0]  s_release_id,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [1:0]  m_size_class,
    output logic [6:0]  m_grant_id,
    output logic [31:0] m_granted_size,
    output logic [7:0]  m_small_free,
    output logic [7:0]  m_medium_free,
    output logic [7:0]  m_large_free,
    output logic [31:0] m_acquire_total,
    output logic [31:0] m_hit_total,
    output logic [31:0] m_miss_total,
    output logic [31:0] m_fallback_total
);
    import scbp_pkg::*;

    class_cfg_t [NumClasses-1:0] cfg_reg;
    logic                        q_valid, q_ready;
    work_t                       q_item;
    result_t                     res;
    logic                        wr_en;
    logic [2:0]                  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[0].count <= CountWidth'(16);
            cfg_reg[1].count <= CountWidth'(16);
            cfg_reg[2].count <= CountWidth'(16);
            cfg_reg[0].size  <= SizeWidth'(4096);
            cfg_reg[1].size  <= SizeWidth'(16384);
            cfg_reg[2].size  <= SizeWidth'(65536);
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SMALL_COUNT:  cfg_reg[0].count <= pwdata[CountWidth-1:0];
                REG_MEDIUM_COUNT: cfg_reg[1].count <= pwdata[CountWidth-1:0];
                REG_LARGE_COUNT:  cfg_reg[2].count <= pwdata[CountWidth-1:0];
                REG_SMALL_SIZE:   cfg_reg[0].size  <= pwdata[SizeWidth-1:0];
                REG_MEDIUM_SIZE:  cfg_reg[1].size  <= pwdata[SizeWidth-1:0];
                REG_LARGE_SIZE:   cfg_reg[2].size  <= pwdata[SizeWidth-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SMALL_COUNT:  prdata = {{(32 - CountWidth){1'b0}}, cfg_reg[0].count};
            REG_MEDIUM_COUNT: prdata = {{(32 - CountWidth){1'b0}}, cfg_reg[1].count};
            REG_LARGE_COUNT:  prdata = {{(32 - CountWidth){1'b0}}, cfg_reg[2].count};
            REG_SMALL_SIZE:   prdata = {{(32 - SizeWidth){1'b0}}, cfg_reg[0].size};
            REG_MEDIUM_SIZE:  prdata = {{(32 - SizeWidth){1'b0}}, cfg_reg[1].size};
            REG_LARGE_SIZE:   prdata = {{(32 - SizeWidth){1'b0}}, cfg_reg[2].size};
            default:          prdata = '0;
        endcase
    end

    scbp_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_size_bytes (s_size_bytes),
        .s_release_id (s_release_id),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item)
    );

    scbp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (res)
    );

    assign m_status         = res.status;
    assign m_size_class     = res.size_class;
    assign m_grant_id       = res.grant_id;
    assign m_granted_size   = res.granted_size;
    assign m_small_free     = res.small_free;
    assign m_medium_free    = res.medium_free;
    assign m_large_free     = res.large_free;
    assign m_acquire_total  = res.acquire_total;
    assign m_hit_total      = res.hit_total;
    assign m_miss_total     = res.miss_total;
    assign m_fallback_total = res.fallback_total;
endmodule

// File: rtl/core/scbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module scbp_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];
    logic [Width-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// File: rtl/core/scbp_front.sv
// Front end: accepts transactions, classifies them and queues them for the back end.
module scbp_front (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            s_valid,
    output logic                                            s_ready,
    input  logic [1:0]                                      s_opcode,
    input  logic [scbp_pkg::ReqWidth-1:0]                   s_size_bytes,
    input  logic [scbp_pkg::IdWidth-1:0]                    s_release_id,
    input  scbp_pkg::class_cfg_t [scbp_pkg::NumClasses-1:0] cfg,
    output logic                                            q_valid,
    input  logic                                            q_ready,
    output scbp_pkg::work_t                                 q_item
);
    import scbp_pkg::*;

    work_t      slot_reg [2];
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic [1:0] fill_reg, fill_next;
    work_t      item;
    logic       push, pop;

    always_comb begin
        item.opcode = opcode_t'(s_opcode);
        item.req    = s_size_bytes;
        item.rid    = s_release_id;
        item.match  = CLASS_NONE;
        for (int c = NumClasses - 1; c >= 0; c--) begin
            item.fits[c] = s_size_bytes <= {{(ReqWidth - SizeWidth){1'b0}}, cfg[c].size};
            if (s_size_bytes == {{(ReqWidth - SizeWidth){1'b0}}, cfg[c].size}) begin
                item.match = 2'(c);
            end
        end
    end

    assign s_ready = fill_reg != 2'd2;
    assign q_valid = fill_reg != 2'd0;
    assign q_item  = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end
endmodule

// File: rtl/core/scbp_back.sv
// Back end: class stacks, free counts, statistics and the result register.
module scbp_back (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  scbp_pkg::class_cfg_t [scbp_pkg::NumClasses-1:0] cfg,
    input  logic                                            q_valid,
    output logic                                            q_ready,
    input  scbp_pkg::work_t                                 q_item,
    output logic                                            m_valid,
    input  logic                                            m_ready,
    output scbp_pkg::result_t                               m_result
);
    import scbp_pkg::*;

    back_state_t                      state_reg, state_next;
    logic [DepthWidth-1:0]            depth_reg [NumClasses];
    logic [DepthWidth-1:0]            depth_next [NumClasses];
    logic [DepthWidth-1:0]            mark_reg [NumClasses];
    logic [DepthWidth-1:0]            mark_next [NumClasses];
    logic [CountWidth-1:0]            lat_reg [NumClasses];
    logic [CountWidth-1:0]            lat_next [NumClasses];
    logic [StatWidth-1:0]             acq_reg, acq_next, hit_reg, hit_next;
    logic [StatWidth-1:0]             miss_reg, miss_next, fb_reg, fb_next;
    status_t                          status_reg, status_next;
    logic [1:0]                       cls_reg, cls_next;
    logic [ReqWidth-1:0]              gsize_reg, gsize_next;
    logic [AddrWidth-1:0]             idx_reg, idx_next;
    logic                             use_mark_reg, use_mark_next;
    logic                             m_valid_reg, m_valid_next;
    result_t                          out_reg, out_next;
    logic [NumClasses-1:0]            ram_we, ram_re;
    logic [AddrWidth-1:0]             ram_waddr, ram_raddr;
    logic [IdWidth-1:0]               ram_rdata [NumClasses];
    logic [1:0]                       served;
    logic [2:0]                       misses;
    logic [NumClasses-1:0]            empty;
    logic [DepthWidth-1:0]            dsel, init_n;
    logic [DepthWidth-1:0]            large_ext;
    logic                             out_free;

    for (genvar g = 0; g < NumClasses; g++) begin : g_stack
        scbp_ram #(.Width(IdWidth), .Depth(StackDepth)) u_ram (
            .aclk  (aclk),
            .we    (ram_we[g]),
            .waddr (ram_waddr),
            .wdata (q_item.rid),
            .re    (ram_re[g]),
            .raddr (ram_raddr),
            .rdata (ram_rdata[g])
        );
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign large_ext = '0;

    always_comb begin
        state_next    = state_reg;
        depth_next    = depth_reg;
        mark_next     = mark_reg;
        lat_next      = lat_reg;
        acq_next      = acq_reg;
        hit_next      = hit_reg;
        miss_next     = miss_reg;
        fb_next       = fb_reg;
        status_next   = status_reg;
        cls_next      = cls_reg;
        gsize_next    = gsize_reg;
        idx_next      = idx_reg;
        use_mark_next = use_mark_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        out_next      = out_reg;
        ram_we        = '0;
        ram_re        = '0;
        ram_waddr     = '0;
        ram_raddr     = '0;
        q_ready       = 1'b0;
        served        = CLASS_NONE;
        misses        = 3'd0;
        dsel          = '0;
        init_n        = '0;

        for (int c = 0; c < NumClasses; c++) begin
            empty[c] = depth_reg[c] == '0;
        end
        for (int c = NumClasses - 1; c >= 0; c--) begin
            if (q_item.fits[c] && !empty[c]) begin
                served = 2'(c);
            end
        end
        misses = 3'(q_item.fits[0] && empty[0])
               + 3'((served > CLASS_SMALL) && q_item.fits[1] && empty[1])
               + 3'((served > CLASS_MEDIUM) && q_item.fits[2] && empty[2])
               + 3'(served == CLASS_NONE);

        unique case (state_reg)
            BK_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    state_next  = BK_OUT;
                    gsize_next  = '0;
                    cls_next    = CLASS_NONE;
                    status_next = ST_DROP_UNKNOWN;
                    case (q_item.opcode)
                        OP_ACQUIRE: begin
                            acq_next  = acq_reg + 1'b1;
                            miss_next = miss_reg + {{(StatWidth - 3){1'b0}}, misses};
                            if (served != CLASS_NONE) begin
                                dsel                  = depth_reg[served] - 1'b1;
                                depth_next[served]    = dsel;
                                idx_next              = dsel[AddrWidth-1:0];
                                use_mark_next         = dsel < mark_reg[served];
                                if (dsel < mark_reg[served]) begin
                                    mark_next[served] = dsel;
                                end
                                ram_re[served]        = 1'b1;
                                ram_raddr             = dsel[AddrWidth-1:0];
                                hit_next              = hit_reg + 1'b1;
                                status_next           = ST_GRANT;
                                cls_next              = served;
                                gsize_next            = {{(ReqWidth - SizeWidth){1'b0}},
                                                         cfg[served].size};
                            end else begin
                                fb_next     = fb_reg + 1'b1;
                                status_next = ST_FALLBACK;
                                if (q_item.fits[2]) begin
                                    gsize_next = {{(ReqWidth - SizeWidth){1'b0}},
                                                  cfg[2].size};
                                end else begin
                                    gsize_next = q_item.req;
                                end
                            end
                        end
                        OP_RELEASE: begin
                            if (q_item.match != CLASS_NONE) begin
                                cls_next = q_item.match;
                                dsel     = depth_reg[q_item.match];
                                if (dsel < {lat_reg[q_item.match], 1'b0}
                                        && dsel < DepthWidth'(StackDepth)) begin
                                    ram_we[q_item.match]     = 1'b1;
                                    ram_waddr                = dsel[AddrWidth-1:0];
                                    depth_next[q_item.match] = dsel + 1'b1;
                                    status_next              = ST_RELEASED;
                                end else begin
                                    status_next = ST_DROP_FULL;
                                end
                            end
                        end
                        OP_INIT: begin
                            status_next = ST_INIT_DONE;
                            for (int c = 0; c < NumClasses; c++) begin
                                init_n = {1'b0, cfg[c].count};
                                if (init_n > DepthWidth'(MaxInitial)) begin
                                    init_n = DepthWidth'(MaxInitial);
                                end
                                if (init_n > DepthWidth'(StackDepth)) begin
                                    init_n = DepthWidth'(StackDepth);
                                end
                                depth_next[c] = init_n;
                                mark_next[c]  = init_n;
                                lat_next[c]   = init_n[CountWidth-1:0];
                            end
                        end
                        default: begin
                            status_next = ST_DROP_UNKNOWN;
                        end
                    endcase
                end
            end
            BK_OUT: begin
                if (out_free) begin
                    state_next              = BK_IDLE;
                    m_valid_next            = 1'b1;
                    out_next.status         = status_reg;
                    out_next.size_class     = cls_reg;
                    out_next.grant_id       = '0;
                    if (status_reg == ST_GRANT) begin
                        out_next.grant_id = use_mark_reg ? idx_reg : ram_rdata[cls_reg];
                    end
                    out_next.granted_size   = gsize_reg;
                    out_next.small_free     = depth_reg[0] | large_ext;
                    out_next.medium_free    = depth_reg[1];
                    out_next.large_free     = depth_reg[2];
                    out_next.acquire_total  = acq_reg;
                    out_next.hit_total      = hit_reg;
                    out_next.miss_total     = miss_reg;
                    out_next.fallback_total = fb_reg;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            m_valid_reg <= 1'b0;
            acq_reg     <= '0;
            hit_reg     <= '0;
            miss_reg    <= '0;
            fb_reg      <= '0;
            for (int c = 0; c < NumClasses; c++) begin
                depth_reg[c] <= '0;
                mark_reg[c]  <= '0;
                lat_reg[c]   <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            acq_reg     <= acq_next;
            hit_reg     <= hit_next;
            miss_reg    <= miss_next;
            fb_reg      <= fb_next;
            depth_reg   <= depth_next;
            mark_reg    <= mark_next;
            lat_reg     <= lat_next;
        end
        status_reg   <= status_next;
        cls_reg      <= cls_next;
        gsize_reg    <= gsize_next;
        idx_reg      <= idx_next;
        use_mark_reg <= use_mark_next;
        out_reg      <= out_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_result = out_reg;
endmodule
